@@ rtl/core/ppc_pkg.sv @@
// Package for the plane projection coefficient pipeline.
// Item structs, widths and shared helper functions; no dependencies.
package ppc_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CoordW      = 32;

  typedef struct packed {
    logic signed [31:0] da_x;
    logic signed [31:0] da_y;
    logic signed [31:0] da_z;
    logic signed [31:0] db_x;
    logic signed [31:0] db_y;
    logic signed [31:0] db_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } ppc_in_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic               degenerate;
    logic               saturated;
  } ppc_out_t;

  // four 33x33 partial products of a split 64-bit multiply
  typedef struct packed {
    logic signed [65:0] hh;
    logic signed [65:0] hl;
    logic signed [65:0] lh;
    logic signed [65:0] ll;
  } mul_part_t;

  // width of an inner product D..H: three floored products of up to 65 bits, signed
  function automatic int unsigned dot_w(input int unsigned frac);
    return 66 - frac;
  endfunction

  // split signed operands into a signed high word and an unsigned low word
  function automatic mul_part_t mul_split(input logic signed [63:0] x,
                                          input logic signed [63:0] y);
    logic signed [32:0] xh, xl, yh, yl;
    mul_part_t p;
    xh = 33'($signed(x[63:32]));
    xl = $signed({1'b0, x[31:0]});
    yh = 33'($signed(y[63:32]));
    yl = $signed({1'b0, y[31:0]});
    p.hh = 66'(xh * yh);
    p.hl = 66'(xh * yl);
    p.lh = 66'(xl * yh);
    p.ll = 66'(xl * yl);
    return p;
  endfunction

  // weighted sum of the partial products
  function automatic logic signed [127:0] mul_join(input mul_part_t p);
    return (128'(p.hh) <<< 64) + (128'(p.hl) <<< 32) + (128'(p.lh) <<< 32) + 128'(p.ll);
  endfunction

endpackage

@@ rtl/core/ppc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, saturating to 32 bits.
// Depends on ppc_pkg. Quotient capped at 2^32; sign applied at the end.
module ppc_div
  import ppc_pkg::*;
#(
  parameter int unsigned NumW  = 128,
  parameter int unsigned DenW  = 128,
  parameter int unsigned SideW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [NumW-1:0]        mag_i,
  input  logic                   neg_i,
  input  logic [DenW-1:0]        den_i,
  input  logic [SideW-1:0]       side_i,
  output logic                   valid_o,
  output logic signed [31:0]     quot_o,
  output logic                   sat_o,
  output logic [SideW-1:0]       side_o
);

  localparam int unsigned RemW = DenW + 1;
  localparam int unsigned QW   = 34;

  logic                 v_q    [NumW+1];
  logic [NumW-1:0]      m_q    [NumW+1];
  logic [RemW-1:0]      r_q    [NumW+1];
  logic [QW-1:0]        q_q    [NumW+1];
  logic [DenW-1:0]      d_q    [NumW+1];
  logic                 n_q    [NumW+1];
  logic [SideW-1:0]     s_q    [NumW+1];

  assign v_q[0] = valid_i;
  assign m_q[0] = mag_i;
  assign r_q[0] = '0;
  assign q_q[0] = '0;
  assign d_q[0] = den_i;
  assign n_q[0] = neg_i;
  assign s_q[0] = side_i;

  // one stage per numerator bit
  for (genvar g = 0; g < NumW; g++) begin : g_stage
    logic [RemW:0]   sh;
    logic [QW-1:0]   qs;
    logic [RemW-1:0] r_d;
    logic [QW-1:0]   q_d;
    logic            vq;
    logic [NumW-1:0] mq;
    logic [RemW-1:0] rq;
    logic [QW-1:0]   qq;
    logic [DenW-1:0] dq;
    logic            nq;
    logic [SideW-1:0] sq;
    always_comb begin
      sh = {r_q[g], m_q[g][NumW-1-g]};
      qs = {q_q[g][QW-2:0], 1'b0};
      if (sh >= {2'b00, d_q[g]}) begin
        r_d = RemW'(sh - {2'b00, d_q[g]});
        qs[0] = 1'b1;
      end else begin
        r_d = RemW'(sh);
      end
      q_d = (qs > QW'(64'h1_0000_0000)) ? QW'(64'h1_0000_0000) : qs;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq <= 1'b0;
      end else begin
        vq <= v_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      mq <= m_q[g];
      rq <= r_d;
      qq <= q_d;
      dq <= d_q[g];
      nq <= n_q[g];
      sq <= s_q[g];
    end
    assign v_q[g+1] = vq;
    assign m_q[g+1] = mq;
    assign r_q[g+1] = rq;
    assign q_q[g+1] = qq;
    assign d_q[g+1] = dq;
    assign n_q[g+1] = nq;
    assign s_q[g+1] = sq;
  end

  // sign and clamp
  logic [QW-1:0] qf;
  always_comb begin
    qf      = q_q[NumW];
    valid_o = v_q[NumW];
    side_o  = s_q[NumW];
    sat_o   = 1'b0;
    if (!n_q[NumW]) begin
      if (qf > QW'(32'h7FFF_FFFF)) begin
        sat_o  = 1'b1;
        quot_o = 32'sh7FFF_FFFF;
      end else begin
        quot_o = qf[31:0];
      end
    end else begin
      if (qf > QW'(32'h8000_0000)) begin
        sat_o  = 1'b1;
        quot_o = 32'sh8000_0000;
      end else begin
        quot_o = 32'(-qf[31:0]);
      end
    end
  end

endmodule

@@ rtl/core/ppc_dot.sv @@
// Inner product stage: products, floor shift and three-term sums of D..H.
// Depends on ppc_pkg. Two register stages.
module ppc_dot
  import ppc_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef,
  localparam int unsigned DotW    = dot_w(FracBits)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  ppc_in_t                item_i,
  output logic                   valid_o,
  output logic signed [DotW-1:0] dd_o,
  output logic signed [DotW-1:0] ee_o,
  output logic signed [DotW-1:0] ff_o,
  output logic signed [DotW-1:0] gg_o,
  output logic signed [DotW-1:0] hh_o
);

  logic signed [31:0] a [3];
  logic signed [31:0] b [3];
  logic signed [32:0] w [3];
  logic signed [65:0] paa_d [3], pab_d [3], pbb_d [3], paw_d [3], pbw_d [3];
  logic signed [65:0] paa_q [3], pab_q [3], pbb_q [3], paw_q [3], pbw_q [3];
  logic v1_q, v2_q;

  always_comb begin
    a[0] = item_i.da_x; a[1] = item_i.da_y; a[2] = item_i.da_z;
    b[0] = item_i.db_x; b[1] = item_i.db_y; b[2] = item_i.db_z;
    w[0] = 33'(item_i.target_x) - 33'(item_i.origin_x);
    w[1] = 33'(item_i.target_y) - 33'(item_i.origin_y);
    w[2] = 33'(item_i.target_z) - 33'(item_i.origin_z);
    for (int i = 0; i < 3; i++) begin
      paa_d[i] = 66'(a[i] * a[i]) >>> FracBits;
      pab_d[i] = 66'(a[i] * b[i]) >>> FracBits;
      pbb_d[i] = 66'(b[i] * b[i]) >>> FracBits;
      paw_d[i] = 66'(66'(a[i]) * 66'(w[i])) >>> FracBits;
      pbw_d[i] = 66'(66'(b[i]) * 66'(w[i])) >>> FracBits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    paa_q <= paa_d; pab_q <= pab_d; pbb_q <= pbb_d; paw_q <= paw_d; pbw_q <= pbw_d;
    dd_o <= DotW'(paa_q[0] + paa_q[1] + paa_q[2]);
    ee_o <= DotW'(pab_q[0] + pab_q[1] + pab_q[2]);
    ff_o <= DotW'(pbb_q[0] + pbb_q[1] + pbb_q[2]);
    gg_o <= DotW'(paw_q[0] + paw_q[1] + paw_q[2]);
    hh_o <= DotW'(pbw_q[0] + pbw_q[1] + pbw_q[2]);
  end

  assign valid_o = v2_q;

endmodule

@@ rtl/core/ppc_solve.sv @@
// Cross products N and M, degenerate test and magnitude for the b divider.
// Depends on ppc_pkg. Three register stages: partial products, products, differences.
module ppc_solve
  import ppc_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef,
  localparam int unsigned DotW    = dot_w(FracBits),
  localparam int unsigned PW      = 2 * DotW,
  localparam int unsigned NW      = PW + 1,
  localparam int unsigned MagW    = NW - 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [DotW-1:0] dd_i,
  input  logic signed [DotW-1:0] ee_i,
  input  logic signed [DotW-1:0] ff_i,
  input  logic signed [DotW-1:0] gg_i,
  input  logic signed [DotW-1:0] hh_i,
  output logic                   valid_o,
  output logic [MagW-1:0]        mag_o,
  output logic                   neg_o,
  output logic [MagW-1:0]        den_o,
  output logic                   degen_o,
  output logic signed [DotW-1:0] dd_o,
  output logic signed [DotW-1:0] ee_o,
  output logic signed [DotW-1:0] gg_o
);

  mul_part_t              pdf_p_q, pee_p_q, pdh_p_q, peg_p_q;
  logic signed [PW-1:0]   pdf_q, pee_q, pdh_q, peg_q;
  logic signed [DotW-1:0] dd1_q, ee1_q, gg1_q, dd2_q, ee2_q, gg2_q;
  logic signed [NW-1:0]   n_w, m_w;
  logic                   v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // partial products, 33x33 each
  always_ff @(posedge clk_i) begin
    pdf_p_q <= mul_split(64'(dd_i), 64'(ff_i));
    pee_p_q <= mul_split(64'(ee_i), 64'(ee_i));
    pdh_p_q <= mul_split(64'(dd_i), 64'(hh_i));
    peg_p_q <= mul_split(64'(ee_i), 64'(gg_i));
    dd1_q <= dd_i; ee1_q <= ee_i; gg1_q <= gg_i;
  end

  // full products
  always_ff @(posedge clk_i) begin
    pdf_q <= PW'(mul_join(pdf_p_q));
    pee_q <= PW'(mul_join(pee_p_q));
    pdh_q <= PW'(mul_join(pdh_p_q));
    peg_q <= PW'(mul_join(peg_p_q));
    dd2_q <= dd1_q; ee2_q <= ee1_q; gg2_q <= gg1_q;
  end

  // differences, sign and degenerate test
  always_comb begin
    m_w = NW'(pdf_q) - NW'(pee_q);
    n_w = NW'(pdh_q) - NW'(peg_q);
  end

  always_ff @(posedge clk_i) begin
    neg_o   <= n_w[NW-1];
    mag_o   <= n_w[NW-1] ? MagW'(-n_w) : MagW'(n_w);
    den_o   <= m_w[MagW-1:0];
    degen_o <= (dd2_q <= 0) || (m_w <= 0);
    dd_o <= dd2_q; ee_o <= ee2_q; gg_o <= gg2_q;
  end

  assign valid_o = v3_q;

endmodule

@@ rtl/core/plane_projection_coefficients.sv @@
// Pipeline: ppc_dot, ppc_solve, the b divider, the a numerator, the a divider, output register.
// Throughput: one item per cycle; busy is tied low, both dividers are bit-pipelined.
// The long latency is set by the two divider chains, one quotient bit per stage.
// Reset: asynchronous active-low rst_ni clears all valid bits; no item in flight survives.
// The receiver cannot stall: done_o is a one-cycle strobe with result_o.
module plane_projection_coefficients
  import ppc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ppc_in_t  item_i,
  output logic     done_o,
  output ppc_out_t result_o
);

  localparam int unsigned DotW = dot_w(FRAC_BITS);
  localparam int unsigned MagW = 2 * DotW;
  localparam int unsigned NbW  = MagW + FRAC_BITS;
  localparam int unsigned PbeW = DotW + 32;
  localparam int unsigned NaW  = PbeW + 1;

  typedef struct packed {
    logic                   degen;
    logic signed [DotW-1:0] dd;
    logic signed [DotW-1:0] ee;
    logic signed [DotW-1:0] gg;
  } side_b_t;

  typedef struct packed {
    logic               degen;
    logic               sat;
    logic signed [31:0] cb;
  } side_a_t;

  logic                   dv;
  logic signed [DotW-1:0] dd, ee, ff;
  logic signed [DotW-1:0] gg, hh;
  logic                   sv, sneg, sdeg;
  logic [MagW-1:0]        smag;
  logic [MagW-1:0]        sden;
  logic signed [DotW-1:0] sdd, see;
  logic signed [DotW-1:0] sgg;
  side_b_t                sb_in, sb_out;
  logic                   bv, bsat;
  logic signed [31:0]     bq;

  assign busy = 1'b0;

  ppc_dot #(.FracBits(FRAC_BITS)) u_dot (
    .clk_i, .rst_ni, .valid_i(start), .item_i, .valid_o(dv),
    .dd_o(dd), .ee_o(ee), .ff_o(ff), .gg_o(gg), .hh_o(hh)
  );

  ppc_solve #(.FracBits(FRAC_BITS)) u_solve (
    .clk_i, .rst_ni, .valid_i(dv), .dd_i(dd), .ee_i(ee), .ff_i(ff), .gg_i(gg),
    .hh_i(hh), .valid_o(sv), .mag_o(smag), .neg_o(sneg), .den_o(sden),
    .degen_o(sdeg), .dd_o(sdd), .ee_o(see), .gg_o(sgg)
  );

  always_comb begin
    sb_in.degen = sdeg;
    sb_in.dd    = sdd;
    sb_in.ee    = see;
    sb_in.gg    = sgg;
  end

  // b = N * 2^F / M
  ppc_div #(.NumW(NbW), .DenW(MagW), .SideW($bits(side_b_t))) u_div_b (
    .clk_i, .rst_ni, .valid_i(sv), .mag_i({smag, {FRAC_BITS{1'b0}}}), .neg_i(sneg),
    .den_i(sden), .side_i(sb_in), .valid_o(bv), .quot_o(bq), .sat_o(bsat),
    .side_o(sb_out)
  );

  // numerator of a: G*2^F - b*E
  mul_part_t              pbe_p_q;
  logic signed [PbeW-1:0] pbe_q;
  logic signed [NaW-1:0]  na_w;
  logic                   av1_q, av2_q, av3_q;
  side_b_t                sb1_q, sb2_q;
  side_a_t                sa1_q, sa2_q, sa_in, sa_out;
  logic [NaW-1:0]         amag_q;
  logic                   aneg_q;
  logic [DotW-1:0]        aden_q;
  logic                   avo, asat;
  logic signed [31:0]     aq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av1_q <= 1'b0;
      av2_q <= 1'b0;
      av3_q <= 1'b0;
    end else begin
      av1_q <= bv;
      av2_q <= av1_q;
      av3_q <= av2_q;
    end
  end

  // b*E partial products
  always_ff @(posedge clk_i) begin
    pbe_p_q     <= mul_split(64'(bq), 64'(sb_out.ee));
    sb1_q       <= sb_out;
    sa1_q.degen <= sb_out.degen;
    sa1_q.sat   <= bsat;
    sa1_q.cb    <= bq;
  end

  // b*E product
  always_ff @(posedge clk_i) begin
    pbe_q <= PbeW'(mul_join(pbe_p_q));
    sb2_q <= sb1_q;
    sa2_q <= sa1_q;
  end

  assign na_w = (NaW'(sb2_q.gg) <<< FRAC_BITS) - NaW'(pbe_q);

  always_ff @(posedge clk_i) begin
    aneg_q <= na_w[NaW-1];
    amag_q <= na_w[NaW-1] ? NaW'(-na_w) : na_w;
    aden_q <= sb2_q.dd;
    sa_in  <= sa2_q;
  end

  ppc_div #(.NumW(NaW), .DenW(DotW), .SideW($bits(side_a_t))) u_div_a (
    .clk_i, .rst_ni, .valid_i(av3_q), .mag_i(amag_q), .neg_i(aneg_q),
    .den_i(aden_q | {{(DotW-1){1'b0}}, sa_in.degen}), .side_i(sa_in), .valid_o(avo),
    .quot_o(aq), .sat_o(asat), .side_o(sa_out)
  );

  // output register
  logic     done_q;
  ppc_out_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= avo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sa_out.degen) begin
      res_q.coef_a     <= '0;
      res_q.coef_b     <= '0;
      res_q.degenerate <= 1'b1;
      res_q.saturated  <= 1'b0;
    end else begin
      res_q.coef_a     <= aq;
      res_q.coef_b     <= sa_out.cb;
      res_q.degenerate <= 1'b0;
      res_q.saturated  <= sa_out.sat | asat;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_deg_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.degenerate |-> result_o.coef_a == 0 && result_o.coef_b == 0
    && !result_o.saturated) else $error("degenerate result not zeroed");
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_done_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avo |=> done_o) else $error("result strobe lost");

endmodule

@@ test/testbench.sv @@
// Testbench for plane_projection_coefficients: random and directed queries.
// Depends on ppc_pkg and the plane_projection_coefficients RTL.
module testbench;
  import ppc_pkg::*;

  localparam int unsigned Frac = FracBitsDef;
  localparam int unsigned Latency = 208;
  localparam int unsigned WatchLimit = 4000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  ppc_in_t  item_i = '0;
  logic     done_o;
  ppc_out_t result_o;

  ppc_out_t coef_queue[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned noise_pct = 15;

  plane_projection_coefficients #(.FRAC_BITS(Frac)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  always #2 clk_i = ~clk_i;

  // sum of three signed products, each floored over 2^Frac
  function automatic logic signed [127:0] dot3(input logic signed [127:0] u[3],
                                               input logic signed [127:0] v[3]);
    logic signed [127:0] s;
    s = 0;
    for (int i = 0; i < 3; i++) s += (u[i] * v[i]) >>> Frac;
    return s;
  endfunction

  // truncating divide, clamped to 32-bit signed
  function automatic logic signed [31:0] quot_clamp(input logic signed [127:0] num,
                                                    input logic signed [127:0] den,
                                                    inout logic sat);
    logic signed [127:0] q;
    q = num / den;
    if (q > 128'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (q < -128'sh80000000) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic ppc_out_t project_coefs(input ppc_in_t it);
    logic signed [127:0] a[3], b[3], w[3];
    logic signed [127:0] dd, ee, ff, gg, hh, den, num;
    logic signed [31:0] cb, ca;
    logic sat;
    ppc_out_t r;
    a = '{128'(it.da_x), 128'(it.da_y), 128'(it.da_z)};
    b = '{128'(it.db_x), 128'(it.db_y), 128'(it.db_z)};
    w[0] = 128'(it.target_x) - 128'(it.origin_x);
    w[1] = 128'(it.target_y) - 128'(it.origin_y);
    w[2] = 128'(it.target_z) - 128'(it.origin_z);
    dd = dot3(a, a); ee = dot3(a, b); ff = dot3(b, b);
    gg = dot3(a, w); hh = dot3(b, w);
    den = dd * ff - ee * ee;
    r = '0;
    if (dd <= 0 || den <= 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    sat = 1'b0;
    num = (dd * hh - ee * gg) <<< Frac;
    cb = quot_clamp(num, den, sat);
    num = (gg <<< Frac) - 128'(cb) * ee;
    ca = quot_clamp(num, dd, sat);
    r.coef_a = ca; r.coef_b = cb; r.saturated = sat;
    return r;
  endfunction

  // send one item, random gap before it; start stays high into the next call
  task automatic send_item(input ppc_in_t it);
    while ($urandom_range(99) < noise_pct) begin
      start <= 1'b0;
      item_i <= ppc_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    coef_queue.push_back(project_coefs(it));
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(65536 * 4)) - 131072);
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return 32'($signed($urandom_range(2000)) - 1000) <<< Frac;
      default: return 32'($signed($urandom_range(600000)) - 300000) <<< 8;
    endcase
  endfunction

  function automatic ppc_in_t rand_query();
    ppc_in_t it;
    it = ppc_in_t'({rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord()});
    // sometimes make B a multiple of A
    if ($urandom_range(9) == 0) begin
      it.db_x = it.da_x * 2; it.db_y = it.da_y * 2; it.db_z = it.da_z * 2;
    end
    return it;
  endfunction

  // extremes, zero and parallel directions, overflow
  task automatic test_corners();
    ppc_in_t it;
    logic [31:0] ext[4];
    ext = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF};
    it = '0; send_item(it);
    it = '0; it.da_x = 32'h10; it.db_y = 32'h10000; it.target_x = 32'h10000;
    send_item(it);
    it = '0; it.da_x = 32'h10000; it.db_x = 32'h30000; it.target_z = 32'h50000;
    send_item(it);
    it = '0; it.da_x = 32'h10000; it.db_y = 32'h10000;
    it.target_x = 32'h00038000; it.target_y = 32'hFFFE0000; it.origin_z = 32'h7;
    send_item(it);
    it = '0; it.da_x = 32'h100; it.db_y = 32'h100;
    it.target_x = 32'h7FFFFFFF; it.origin_y = 32'h80000000; send_item(it);
    it = '0; it.da_x = 32'h100; it.db_y = 32'h100;
    it.target_x = 32'h80000000; it.target_y = 32'h7FFFFFFF; send_item(it);
    for (int k = 0; k < 4; k++) begin
      it = ppc_in_t'({12{ext[k]}});
      send_item(it);
      it = ppc_in_t'({6{ext[k], ext[3 - k]}});
      send_item(it);
    end
    it = ppc_in_t'({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h0,
                    32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
    send_item(it);
  endtask

  task automatic test_random(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) send_item(rand_query());
  endtask

  // back-to-back items, one per cycle
  task automatic test_streaming(input int unsigned n);
    noise_pct = 0;
    test_random(n);
    noise_pct = 15;
  endtask

  // check each result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (coef_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result_o);
      end else begin
        ppc_out_t exp_r;
        exp_r = coef_queue.pop_front();
        if (result_o.coef_a !== exp_r.coef_a || result_o.coef_b !== exp_r.coef_b ||
            result_o.degenerate !== exp_r.degenerate ||
            result_o.saturated !== exp_r.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected a=%h b=%h deg=%b sat=%b, got a=%h b=%h deg=%b sat=%b",
                     exp_r.coef_a, exp_r.coef_b, exp_r.degenerate, exp_r.saturated,
                     result_o.coef_a, result_o.coef_b, result_o.degenerate,
                     result_o.saturated);
        end
      end
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("plane_projection_coefficients: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_corners();
    test_random(150);
    test_streaming(100);
    test_random(150);
    start <= 1'b0;
    while (coef_queue.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0) $display("plane_projection_coefficients: match");
    else $display("plane_projection_coefficients: mismatch");
    $finish;
  end

endmodule
